/* design/rba_pkg.sv */
// Package for the reference-counted block allocator: constants, command codes,
// payload structs and the controller state enum. No dependencies.
`default_nettype none
package rba_pkg;
  localparam int unsigned EntriesPerGroup = 1024;
  localparam int unsigned TableDepth      = 65536;
  localparam int unsigned HintDepth       = 16;
  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned OffW  = $clog2(EntriesPerGroup);
  localparam int unsigned HintW = $clog2(HintDepth);

  typedef enum logic [2:0] {
    CMD_FORMAT  = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_ADDREF  = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_GROUPS = 2'd0,
    REG_DISK   = 2'd1,
    REG_SUPER  = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RMW_RD, ST_RMW_WR, ST_FMT, ST_HINT_RD, ST_HINT_CHK,
    ST_SCAN_RD, ST_SCAN_CHK, ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] block_index;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [15:0]        granted_block;
    logic signed [15:0] ref_count;
  } rsp_t;
endpackage
`default_nettype wire

/* design/rba_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module rba_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* design/refcount_block_allocator.sv */
// Top level: APB config registers, command controller, count RAM and hint FIFO RAM.
// Depends on rba_pkg and rba_ram.
//
// channel   dir  handshake            payload
// command   in   start_i & !busy_o    req_i  (rba_pkg::req_t)
// result    out  done_o, one cycle    rsp_o  (rba_pkg::rsp_t)
// config    in   APB psel/penable     paddr/pwdata
//
// addref/release/query: ST_RMW_RD reads the count RAM, ST_RMW_WR writes it.
// format: one count entry written per cycle, TableDepth entries in all.
// alloc: each hint passes ST_HINT_RD, ST_HINT_CHK and ST_SCAN_CHK; each scanned
//   entry passes ST_SCAN_RD and ST_SCAN_CHK, as the count RAM has a single port.
//   Unused codes pass ST_DONE. busy_o covers the result cycle, so the next beat can
//   be accepted in the cycle after the result beat. After reset a clearing sweep
//   zeroes the count RAM, busy_o high meanwhile. The receiver cannot stall results.
`default_nettype none
module refcount_block_allocator (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire rba_pkg::req_t   req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output rba_pkg::rsp_t        rsp_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rba_pkg::*;

  logic [6:0]  groups_q;
  logic [16:0] disk_q;
  logic [15:0] super_q;
  logic        cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= 7'd64;
      disk_q   <= 17'h10000;
      super_q  <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_GROUPS: groups_q <= pwdata[6:0];
        REG_DISK:   disk_q   <= pwdata[16:0];
        REG_SUPER:  super_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GROUPS: prdata = {25'd0, groups_q};
      REG_DISK:   prdata = {15'd0, disk_q};
      REG_SUPER:  prdata = {16'd0, super_q};
      default:    prdata = '0;
    endcase
  end

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  logic [IdxW:0]  ptr_q, ptr_d;      // sweep / scan position, one bit wider
  logic [HintW:0] fill_q, fill_d;
  logic [HintW-1:0] head_q, head_d;
  logic           have_q, have_d;
  logic           claim_q, claim_d;  // scan has claimed a block
  logic [IdxW-1:0] grant_q, grant_d;
  logic           clear_q, clear_d;  // post-reset clearing sweep
  rsp_t           rsp_d;
  logic           done_d;

  logic            c_we;
  logic [IdxW-1:0] c_addr;
  logic [15:0]     c_wdata, c_rdata;
  logic            h_we;
  logic [HintW-1:0] h_addr;
  logic [15:0]     h_wdata, h_rdata;

  rba_ram #(.Width(16), .Depth(TableDepth)) u_count (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );
  rba_ram #(.Width(16), .Depth(HintDepth)) u_hint (
    .clk_i, .we_i(h_we), .addr_i(h_addr), .wdata_i(h_wdata), .rdata_o(h_rdata)
  );

  // format pattern for the entry at ptr
  logic [17:0] lim, meta_hi, last_base, pos;
  logic [IdxW-1:0] pidx;
  logic [OffW-1:0] rem;
  logic [15:0] fmt_val;
  logic        in_scan;
  assign pidx      = ptr_q[IdxW-1:0];
  assign pos       = {1'b0, ptr_q};
  assign lim       = ({11'd0, groups_q} << OffW) > 18'(TableDepth) ?
                     18'(TableDepth) : ({11'd0, groups_q} << OffW);
  assign meta_hi   = {2'd0, super_q} + {11'd0, groups_q};
  assign last_base = ({11'd0, groups_q} - 18'd1) << OffW;
  assign rem       = disk_q[OffW-1:0];
  assign in_scan   = pos < lim;

  always_comb begin
    fmt_val = '0;
    if (groups_q != 0 && rem != 0 && pos >= last_base + {8'd0, rem} &&
        pos < last_base + 18'(EntriesPerGroup)) begin
      fmt_val = 16'hFFFF;
    end else if (pos >= {2'd0, super_q} && pos <= meta_hi && pos < lim) begin
      fmt_val = 16'd1;
    end
  end

  logic [15:0] cnt_new;
  always_comb begin
    cnt_new = c_rdata;
    if (req_q.command == CMD_ADDREF) begin
      if (c_rdata != 16'h7FFF) cnt_new = c_rdata + 16'd1;
    end else if (req_q.command == CMD_RELEASE) begin
      if (c_rdata == 0 || c_rdata[15]) cnt_new = '0;
      else cnt_new = c_rdata - 16'd1;
    end
  end

  logic [HintW-1:0] tail;
  assign tail = head_q + fill_q[HintW-1:0];

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    ptr_d   = ptr_q;
    fill_d  = fill_q;
    head_d  = head_q;
    have_d  = have_q;
    claim_d = claim_q;
    grant_d = grant_q;
    clear_d = clear_q;
    c_we = 1'b0; c_addr = pidx; c_wdata = '0;
    h_we = 1'b0; h_addr = head_q; h_wdata = '0;
    done_d = 1'b0;
    rsp_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (clear_q) begin
          c_we = 1'b1;
          ptr_d = ptr_q + 1'b1;
          if (pidx == IdxW'(TableDepth - 1)) begin
            clear_d = 1'b0;
            ptr_d = '0;
          end
        end else if (start_i && !busy_o) begin
          req_d = req_i;
          ptr_d = '0;
          claim_d = 1'b0;
          unique case (req_i.command)
            CMD_FORMAT: state_d = ST_FMT;
            CMD_ALLOC: begin
              have_d = 1'b0;
              state_d = (fill_q != 0) ? ST_HINT_RD : ST_SCAN_RD;
            end
            CMD_ADDREF, CMD_RELEASE, CMD_QUERY: state_d = ST_RMW_RD;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RMW_RD: begin
        c_addr = req_q.block_index;
        state_d = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        c_addr = req_q.block_index;
        c_we = 1'b1;
        c_wdata = cnt_new;
        if (req_q.command == CMD_RELEASE && cnt_new == 0 && fill_q != HintDepth) begin
          h_we = 1'b1; h_addr = tail; h_wdata = req_q.block_index;
          fill_d = fill_q + 1'b1;
        end
        done_d = 1'b1;
        rsp_d.ref_count = cnt_new;
        state_d = ST_IDLE;
      end
      ST_FMT: begin
        c_we = 1'b1;
        c_wdata = fmt_val;
        ptr_d = ptr_q + 1'b1;
        fill_d = '0; head_d = '0;
        if (pidx == IdxW'(TableDepth - 1)) begin
          done_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_HINT_RD: begin
        // hint RAM addressed at head; data arrives next cycle
        head_d = head_q + 1'b1;
        fill_d = fill_q - 1'b1;
        state_d = ST_HINT_CHK;
      end
      ST_HINT_CHK: begin
        // h_rdata valid now; issue count read this cycle via c_addr, checked in RMW-like path
        c_addr = h_rdata;
        grant_d = h_rdata;
        state_d = ST_SCAN_CHK;
        have_d = 1'b1;  // marks hint check mode in SCAN_CHK
      end
      ST_SCAN_RD: begin
        if (!in_scan || ptr_q[IdxW]) begin
          done_d = 1'b1;
          rsp_d.status = 1'b1;
          state_d = ST_IDLE;
        end else begin
          c_addr = pidx;
          state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (have_q) begin
          // hint candidate at grant_q
          c_addr = grant_q;
          if (c_rdata == 0) begin
            c_we = 1'b1; c_wdata = 16'd1;
            done_d = 1'b1;
            rsp_d.granted_block = grant_q;
            rsp_d.ref_count = 16'sd1;
            state_d = ST_IDLE;
          end else begin
            have_d = 1'b0;
            state_d = (fill_q != 0) ? ST_HINT_RD : ST_SCAN_RD;
          end
        end else begin
          c_addr = pidx;
          ptr_d = ptr_q + 1'b1;
          if (c_rdata == 0) begin
            if (!claim_q) begin
              c_we = 1'b1; c_wdata = 16'd1;
              grant_d = pidx;
              claim_d = 1'b1;
            end else if (fill_q != HintDepth) begin
              h_we = 1'b1; h_addr = tail; h_wdata = pidx;
              fill_d = fill_q + 1'b1;
            end else begin
              state_d = ST_DONE;
            end
          end
          if (state_d != ST_DONE) begin
            if (pidx[OffW-1:0] == {OffW{1'b1}} && (claim_q ||
                (c_rdata == 0))) state_d = ST_DONE;
            else state_d = ST_SCAN_RD;
          end
          if (state_d == ST_SCAN_RD && claim_q &&
              !({1'b0, ptr_d} < lim)) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_d = 1'b1;
        if (claim_q) begin
          rsp_d.granted_block = grant_q;
          rsp_d.ref_count = 16'sd1;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      fill_q  <= '0;
      head_q  <= '0;
      have_q  <= 1'b0;
      claim_q <= 1'b0;
      clear_q <= 1'b1;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      have_q  <= have_d;
      claim_q <= claim_d;
      clear_q <= clear_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    grant_q <= grant_d;
    rsp_o   <= rsp_d;
  end

  assign busy_o = clear_q || state_q != ST_IDLE || done_o;

  property p_fill_bound;
    @(posedge clk_i) disable iff (!rst_ni) fill_q <= HintDepth;
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("hint fill overflow");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == ST_IDLE) else $error("result while busy");
  a_no_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_q |-> state_q == ST_IDLE) else $error("command during clear");
endmodule
`default_nettype wire

/* bench/refcount_block_allocator_checker.sv */
// Checker for the refcount block allocator: watches command, result and APB write beats,
// predicts each result from its own copy of the count table and hint FIFO, and compares.
// Depends on rba_pkg.
`timescale 1ns / 100ps
module refcount_block_allocator_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire rba_pkg::req_t req_i,
  input  wire logic          done_i,
  input  wire rba_pkg::rsp_t rsp_i,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [3:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  input  wire logic          pready_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import rba_pkg::*;

  logic [15:0] counts [TableDepth];
  logic [15:0] hints [$];
  rsp_t        owed_rsp [$];
  int unsigned groups_in_use = 64;
  int unsigned disk_blocks = 65536;
  int unsigned super_idx = 0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    foreach (counts[k]) counts[k] = '0;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic int unsigned scan_limit();
    int unsigned lim;
    lim = groups_in_use * EntriesPerGroup;
    return (lim < TableDepth) ? lim : TableDepth;
  endfunction

  function automatic rsp_t predict_allocator(req_t rq);
    rsp_t        r;
    int unsigned lim, b, rem, base, g, j, ix;
    logic [15:0] c, h;
    bit          got, stop;
    r = '0;
    got = 0;
    stop = 0;
    case (rq.command)
      CMD_FORMAT: begin
        lim = scan_limit();
        foreach (counts[k]) counts[k] = '0;
        hints.delete();
        for (b = super_idx; b <= super_idx + groups_in_use; b++)
          if (b < lim) counts[b] = 16'd1;
        rem = disk_blocks % EntriesPerGroup;
        if (groups_in_use > 0 && rem != 0) begin
          base = (groups_in_use - 1) * EntriesPerGroup;
          for (; rem < EntriesPerGroup; rem++)
            if (base + rem < TableDepth) counts[base + rem] = 16'hFFFF;
        end
      end
      CMD_ALLOC: begin
        while (hints.size() > 0 && !got) begin
          h = hints.pop_front();
          if (counts[h] == 0) begin
            counts[h] = 16'd1;
            r.granted_block = h;
            got = 1;
          end
        end
        lim = scan_limit();
        for (g = 0; g < groups_in_use && !got && !stop; g++) begin
          for (j = 0; j < EntriesPerGroup && !stop; j++) begin
            ix = g * EntriesPerGroup + j;
            if (ix < lim && counts[ix] == 0) begin
              if (!got) begin
                counts[ix] = 16'd1;
                r.granted_block = ix[15:0];
                got = 1;
              end else if (hints.size() < HintDepth) begin
                hints.push_back(ix[15:0]);
              end else begin
                stop = 1;
              end
            end
          end
          if (got) stop = 1;
        end
        if (got) r.ref_count = 16'sd1;
        else r.status = 1'b1;
      end
      CMD_ADDREF, CMD_RELEASE, CMD_QUERY: begin
        c = counts[rq.block_index];
        if (rq.command == CMD_ADDREF) begin
          if (c != 16'h7FFF) c = c + 16'd1;
        end else if (rq.command == CMD_RELEASE) begin
          // negative counts floor at zero like a zero count
          if (c == 0 || c[15]) c = '0;
          else c = c - 16'd1;
          if (c == 0 && hints.size() < HintDepth) hints.push_back(rq.block_index);
        end
        counts[rq.block_index] = c;
        r.ref_count = c;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (owed_rsp.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 16'd1, 16'd0);
        end else begin
          want = owed_rsp.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", {15'd0, rsp_i.status}, {15'd0, want.status});
          if (rsp_i.granted_block !== want.granted_block)
            report_mismatch("granted_block", rsp_i.granted_block, want.granted_block);
          if (rsp_i.ref_count !== want.ref_count)
            report_mismatch("ref_count", rsp_i.ref_count, want.ref_count);
        end
      end
      if (start_i && !busy_i) owed_rsp.push_back(predict_allocator(req_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_GROUPS: groups_in_use = pwdata_i[6:0];
          REG_DISK:   disk_blocks = pwdata_i[16:0];
          REG_SUPER:  super_idx = pwdata_i[15:0];
          default: ;
        endcase
      end
      pending_o = owed_rsp.size();
    end
  end
endmodule

/* bench/refcount_block_allocator_tb.sv */
// Testbench top for refcount_block_allocator: clock, reset, APB setup and command stimulus.
// Depends on rba_pkg, the DUT and refcount_block_allocator_checker.
`timescale 1ns / 100ps
module refcount_block_allocator_tb;
  import rba_pkg::*;

  localparam int unsigned StallLimit = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o, done_o, pready;
  rsp_t        rsp_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  int unsigned fail_count, pending;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  refcount_block_allocator dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  refcount_block_allocator_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o), .rsp_i(rsp_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic issue(input cmd_e cmd, input logic [15:0] idx);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i) start_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i <= '{command: cmd, block_index: idx};
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic settle();
    @(negedge clk_i) start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {r, 2'b00}; pwdata <= val;
    @(negedge clk_i) penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic setup_disk(input int unsigned groups, input int unsigned blocks,
                            input int unsigned sb);
    settle();
    write_reg(REG_GROUPS, groups);
    write_reg(REG_DISK, blocks);
    write_reg(REG_SUPER, sb);
    issue(CMD_FORMAT, 16'($urandom));
  endtask

  // mostly traffic near a window so allocs, releases and hints interact
  task automatic random_traffic(input int unsigned n, input int unsigned base,
                                input int unsigned span);
    int unsigned pick;
    logic [15:0] idx;
    repeat (n) begin
      pick = $urandom_range(99);
      idx = (pick % 5 == 0) ? 16'($urandom) : 16'(base + $urandom_range(span));
      if (pick < 30) issue(CMD_ALLOC, 16'($urandom));
      else if (pick < 50) issue(CMD_ADDREF, idx);
      else if (pick < 75) issue(CMD_RELEASE, idx);
      else if (pick < 95) issue(CMD_QUERY, idx);
      else issue(cmd_e'(3'($urandom_range(5, 7))), idx);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset configuration, table all zero
    idle_pct = 22;
    issue(CMD_QUERY, 16'h0000);
    issue(CMD_QUERY, 16'hFFFF);
    issue(CMD_ADDREF, 16'd5);
    issue(CMD_ADDREF, 16'd5);
    repeat (3) issue(CMD_RELEASE, 16'd5);
    issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_ADDREF, 16'hFFFF);
    issue(cmd_e'(3'd7), 16'hAAAA);
    issue(cmd_e'(3'd5), 16'h5555);
    issue(cmd_e'(3'd6), 16'h0F0F);
    // back-to-back addrefs on one block
    idle_pct = 0;
    repeat (8) issue(CMD_ADDREF, 16'd9);
    issue(CMD_RELEASE, 16'd9);
    idle_pct = 22;
    issue(CMD_FORMAT, '0);
    issue(CMD_ALLOC, '0);
    issue(CMD_QUERY, 16'd64);
    random_traffic(80, 0, 200);

    // two groups, partial last group marked reserved, metadata near a group edge
    setup_disk(2, 1500, 1020);
    issue(CMD_ADDREF, 16'd1600);
    issue(CMD_RELEASE, 16'd1700);
    issue(CMD_QUERY, 16'd1022);
    repeat (6) issue(CMD_ALLOC, '0);
    random_traffic(60, 400, 120);
    repeat (60) issue(CMD_ALLOC, '0);
    issue(CMD_ALLOC, '0);
    random_traffic(80, 440, 60);

    // no groups at all, empty disk, top superblock index
    idle_pct = 51;
    setup_disk(0, 0, 65535);
    issue(CMD_ALLOC, '0);
    random_traffic(120, 65400, 135);

    // full table, disk one short so the last entry is reserved
    idle_pct = 0;
    setup_disk(64, 65535, 65535);
    issue(CMD_QUERY, 16'hFFFF);
    random_traffic(110, 0, 300);

    settle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

/* filelist.f */
design/rba_pkg.sv
design/rba_ram.sv
design/refcount_block_allocator.sv
bench/refcount_block_allocator_checker.sv
bench/refcount_block_allocator_tb.sv
